@@ rtl/sbn_pkg.sv @@
// Shared widths, stage layout and search types for the Sobel height-to-normal unit.
package sbn_pkg;

	localparam int HW    = 16;   // height sample width
	localparam int GW    = 20;   // signed gradient width
	localparam int MW    = 19;   // gradient magnitude width
	localparam int SW    = 24;   // strength width
	localparam int SQW   = 38;   // gradient square width
	localparam int SSW   = 48;   // strength square width
	localparam int QW    = 49;   // squared length width
	localparam int CW    = 66;   // compare width for the root search
	localparam int JW    = 7;    // search result width
	localparam int NSRCH = JW;   // one search stage per result bit
	localparam int SRCH_FIRST = 3;
	localparam int NSTG  = SRCH_FIRST + NSRCH + 1;
	localparam int OUT_STG = NSTG - 1;
	localparam int OW    = 8;

	localparam logic [OW-1:0] MID_CODE = 8'd128;
	localparam logic [OW-1:0] NEG_TOP  = 8'd127;
	localparam logic [SW-1:0] STRENGTH_RST = 24'h010000;

	typedef struct packed {
		logic [CW-1:0] q4;      // 4 * squared length
		logic [CW-1:0] a;       // 65025 * component squared
		logic          strict;  // component is negative
	} srch_in_t;

	typedef struct packed {
		logic [JW-1:0] j;
		logic          strict;
	} srch_out_t;

endpackage

@@ rtl/sobel_height_to_normal_unit.sv @@
// Sobel height-to-normal top level: gradients, squares, root search and RGB mapping.
// Layout: 11 register stages (3 front, 7 search, output); out_valid is the last stage's valid bit.
// Throughput: one item per cycle while out_ready holds; each stage moves whenever the stage after it can take data.
// The 7-stage search per component sets the depth, one result bit per stage.
// Reset clears all stage valid bits and loads strength with 1.0 (0x010000).
module sobel_height_to_normal_unit import sbn_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [SW-1:0] cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [HW-1:0] h_left,
	input  logic [HW-1:0] h_right,
	input  logic [HW-1:0] h_top,
	input  logic [HW-1:0] h_bottom,
	input  logic [HW-1:0] h_top_left,
	input  logic [HW-1:0] h_top_right,
	input  logic [HW-1:0] h_bottom_left,
	input  logic [HW-1:0] h_bottom_right,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [OW-1:0] red_out,
	output logic [OW-1:0] green_out,
	output logic [OW-1:0] blue_out
);

	logic [SW-1:0]   strength_q;
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	logic signed [GW-1:0] dx_s1, dy_s1;
	logic [SW-1:0]        str_s1;

	logic                 nx_s2, ny_s2;
	logic [SQW-1:0]       sqx_s2, sqy_s2;
	logic [SSW-1:0]       sqs_s2;

	logic [QW-1:0]        q_s3;
	logic [CW-1:0]        ax_s3, ay_s3, as_s3;
	logic                 nx_s3, ny_s3, zero_s3;

	logic                 zero_sr [NSRCH];
	srch_in_t             sin_x, sin_y, sin_z;
	srch_out_t            sres_x, sres_y, sres_z;

	logic [OW-1:0]        red_q, green_q, blue_q;

	logic signed [GW-1:0] dx_c, dy_c, adx_c, ady_c;
	logic [MW-1:0]        ux_c, uy_c;

	function automatic logic signed [GW-1:0] ext(input logic [HW-1:0] h);
		ext = signed'({{(GW-HW){1'b0}}, h});
	endfunction

	function automatic logic [CW-1:0] times_65025(input logic [CW-1:0] v);
		// 65025 = 2^16 - 2^9 + 1
		times_65025 = (v << 16) - (v << 9) + v;
	endfunction

	function automatic logic [OW-1:0] map_out(input logic zero, input srch_out_t r);
		if (zero)
			map_out = MID_CODE;
		else if (r.strict)
			map_out = NEG_TOP - OW'(r.j);
		else
			map_out = MID_CODE + OW'(r.j);
	endfunction

	// stage enables: a stage moves when empty or when the next one moves
	always_comb begin
		en[OUT_STG] = !vld_q[OUT_STG] || out_ready;
		for (int i = OUT_STG - 1; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= STRENGTH_RST;
		end else if (cfg_we) begin
			strength_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= in_valid;
			for (int i = 1; i < NSTG; i++) begin
				if (en[i])
					vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// stage 1: Sobel gradients
	assign dx_c = ext(h_top_right) + (ext(h_right) <<< 1) + ext(h_bottom_right)
		- ext(h_top_left) - (ext(h_left) <<< 1) - ext(h_bottom_left);
	assign dy_c = ext(h_bottom_left) + (ext(h_bottom) <<< 1) + ext(h_bottom_right)
		- ext(h_top_left) - (ext(h_top) <<< 1) - ext(h_top_right);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1  <= dx_c;
			dy_s1  <= dy_c;
			str_s1 <= strength_q;
		end
	end

	// stage 2: magnitudes and squares
	assign adx_c = dx_s1[GW-1] ? -dx_s1 : dx_s1;
	assign ady_c = dy_s1[GW-1] ? -dy_s1 : dy_s1;
	assign ux_c  = adx_c[MW-1:0];
	assign uy_c  = ady_c[MW-1:0];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			nx_s2  <= dx_s1[GW-1];
			ny_s2  <= dy_s1[GW-1];
			sqx_s2 <= SQW'(ux_c) * SQW'(ux_c);
			sqy_s2 <= SQW'(uy_c) * SQW'(uy_c);
			sqs_s2 <= SSW'(str_s1) * SSW'(str_s1);
		end
	end

	// stage 3: squared length and scaled component squares
	always_ff @(posedge clk) begin
		if (en[2]) begin
			q_s3    <= QW'(sqx_s2) + QW'(sqy_s2) + QW'(sqs_s2);
			ax_s3   <= times_65025(CW'(sqx_s2));
			ay_s3   <= times_65025(CW'(sqy_s2));
			as_s3   <= times_65025(CW'(sqs_s2));
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;
			zero_s3 <= (sqx_s2 == '0) && (sqy_s2 == '0) && (sqs_s2 == '0);
		end
	end

	assign sin_x = '{q4: CW'({q_s3, 2'b00}), a: ax_s3, strict: nx_s3};
	assign sin_y = '{q4: CW'({q_s3, 2'b00}), a: ay_s3, strict: ny_s3};
	assign sin_z = '{q4: CW'({q_s3, 2'b00}), a: as_s3, strict: 1'b0};

	sbn_search u_srch_x (
		.clk (clk),
		.en  (en[SRCH_FIRST +: NSRCH]),
		.src (sin_x),
		.res (sres_x)
	);

	sbn_search u_srch_y (
		.clk (clk),
		.en  (en[SRCH_FIRST +: NSRCH]),
		.src (sin_y),
		.res (sres_y)
	);

	sbn_search u_srch_z (
		.clk (clk),
		.en  (en[SRCH_FIRST +: NSRCH]),
		.src (sin_z),
		.res (sres_z)
	);

	// zero-length flag rides alongside the search stages
	always_ff @(posedge clk) begin
		for (int i = 0; i < NSRCH; i++) begin
			if (en[SRCH_FIRST + i])
				zero_sr[i] <= (i == 0) ? zero_s3 : zero_sr[(i == 0) ? 0 : i - 1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en[OUT_STG]) begin
			red_q   <= map_out(zero_sr[NSRCH-1], sres_x);
			green_q <= map_out(zero_sr[NSRCH-1], sres_y);
			blue_q  <= map_out(zero_sr[NSRCH-1], sres_z);
		end
	end

	assign out_valid = vld_q[OUT_STG];
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;

	// strength is never negative, so blue never drops below the midpoint
	a_blue_upper: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (blue_out >= MID_CODE))
		else $error("blue below midpoint");

	// input can only stall when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_q))
		else $error("input stalled with a free stage");

	// an item taken at the input shows up in stage one next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted item lost at entry");

endmodule

@@ rtl/sbn_search.sv @@
// Pipelined bit-serial search for the largest j with 4*j*j*q below (or at) 65025*c*c.
module sbn_search import sbn_pkg::*; (
	input  logic             clk,
	input  logic [NSRCH-1:0] en,
	input  srch_in_t         src,
	output srch_out_t        res
);

	logic [JW-1:0] j_o  [NSRCH];
	logic [CW-1:0] p_o  [NSRCH];
	logic [CW-1:0] r_o  [NSRCH];
	logic [CW-1:0] a_o  [NSRCH];
	logic [CW-1:0] q4_o [NSRCH];
	logic          st_o [NSRCH];

	for (genvar i = 0; i < NSRCH; i++) begin : g_stg
		localparam int B = NSRCH - 1 - i;
		logic [JW-1:0] jin;
		logic [CW-1:0] pin, rin, ain, qin, pt;
		logic          sin, hit;
		logic [JW-1:0] j_s;
		logic [CW-1:0] p_s, r_s, a_s, q4_s;
		logic          strict_s;

		if (i == 0) begin : g_first
			assign jin = '0;
			assign pin = '0;
			assign rin = '0;
			assign ain = src.a;
			assign qin = src.q4;
			assign sin = src.strict;
		end else begin : g_next
			assign jin = j_o[i-1];
			assign pin = p_o[i-1];
			assign rin = r_o[i-1];
			assign ain = a_o[i-1];
			assign qin = q4_o[i-1];
			assign sin = st_o[i-1];
		end

		// (J + 2^B)^2 * q4 = P + 2^(B+1) * J*q4 + 2^(2B) * q4
		assign pt  = pin + (rin << (B + 1)) + (qin << (2 * B));
		assign hit = sin ? (pt < ain) : (pt <= ain);

		always_ff @(posedge clk) begin
			if (en[i]) begin
				a_s      <= ain;
				q4_s     <= qin;
				strict_s <= sin;
				if (hit) begin
					j_s <= jin | (JW'(1) << B);
					p_s <= pt;
					r_s <= rin + (qin << B);
				end else begin
					j_s <= jin;
					p_s <= pin;
					r_s <= rin;
				end
			end
		end

		assign j_o[i]  = j_s;
		assign p_o[i]  = p_s;
		assign r_o[i]  = r_s;
		assign a_o[i]  = a_s;
		assign q4_o[i] = q4_s;
		assign st_o[i] = strict_s;
	end

	assign res.j      = j_o[NSRCH-1];
	assign res.strict = st_o[NSRCH-1];

endmodule
